// ===== hw/rtl/ille_pkg.sv =====
// Shared types and constants for the indexed linked list engine.
package ille_pkg;

  localparam int unsigned ITEM_W = 11;
  localparam int unsigned SUM_W  = 20;
  localparam int unsigned JOIN_N = 4;

  localparam logic [ITEM_W-1:0] LIST_LEN_RST = 11'd1024;
  localparam logic [SUM_W-1:0]  SUM_MAX      = 20'hFFFFF;

  typedef enum logic [2:0] {
    MODE_INIT  = 3'd0,
    MODE_LEFT  = 3'd1,
    MODE_RIGHT = 3'd2,
    MODE_SWAP  = 3'd3,
    MODE_REV   = 3'd4,
    MODE_SUM   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_SKIP = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INIT,
    S_INIT_HEAD,
    S_RD_X,
    S_CALC,
    S_JOIN,
    S_WALK_RD,
    S_WALK_ACC,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [ITEM_W-1:0] item_x;
    logic [ITEM_W-1:0] item_y;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] odd_sum;
    logic [1:0]       status;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic init_start;
    logic init_step;
    logic init_head;
    logic flip_rev;
    logic rd_y;
    logic rd_x;
    logic calc;
    logic join_step;
    logic walk_start;
    logic walk_rd;
    logic walk_acc;
    logic set_bad;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] mode;
    logic       bad;
    logic       skip;
    logic       init_last;
    logic       join_last;
    logic       walk_end;
  } stat_t;

endpackage

// ===== hw/rtl/ille_ctrl.sv =====
// Sequencing state machine for the indexed linked list engine.
module ille_ctrl import ille_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.mode)
          MODE_INIT: begin
            cmd_o.init_start = 1'b1;
            state_d          = S_INIT;
          end
          MODE_LEFT, MODE_RIGHT, MODE_SWAP: begin
            if (stat_i.bad) begin
              cmd_o.set_bad = 1'b1;
              state_d       = S_DONE;
            end else begin
              cmd_o.rd_y = 1'b1;
              state_d    = S_RD_X;
            end
          end
          MODE_REV: begin
            cmd_o.flip_rev = 1'b1;
            state_d        = S_DONE;
          end
          MODE_SUM: begin
            cmd_o.walk_start = 1'b1;
            state_d          = S_WALK_RD;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (stat_i.init_last) state_d = S_INIT_HEAD;
      end
      S_INIT_HEAD: begin
        cmd_o.init_head = 1'b1;
        state_d         = S_DONE;
      end
      S_RD_X: begin
        cmd_o.rd_x = 1'b1;
        state_d    = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = stat_i.skip ? S_DONE : S_JOIN;
      end
      S_JOIN: begin
        cmd_o.join_step = 1'b1;
        if (stat_i.join_last) state_d = S_DONE;
      end
      S_WALK_RD: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = S_WALK_ACC;
      end
      S_WALK_ACC: begin
        cmd_o.walk_acc = 1'b1;
        state_d        = stat_i.walk_end ? S_DONE : S_WALK_RD;
      end
      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/ille_dpath.sv =====
// Link tables, list registers and arithmetic for the indexed linked list engine.
module ille_dpath import ille_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ITEM_W-1:0] cfg_wdata_i,
  input  in_item_t          in_data_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output out_item_t         out_data_o
);

  localparam int unsigned AW    = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CW    = (AW > ITEM_W) ? AW : ITEM_W;
  localparam int unsigned SW    = ((AW > SUM_W) ? AW : SUM_W) + 1;
  localparam int unsigned DEPTH = MAX_ITEMS + 1;
  localparam logic [AW-1:0] MAX_A = AW'(MAX_ITEMS);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);

  // Control registers
  logic [ITEM_W-1:0] list_len_q;
  logic [AW-1:0]     active_q;
  logic              reversed_q;

  // Working registers
  in_item_t          item_q;
  logic [AW-1:0]     cnt_q;
  logic [AW-1:0]     pos_q;
  logic [SUM_W-1:0]  sum_q;
  logic [1:0]        status_q;
  logic [AW-1:0]     py_q, ny_q;
  logic [AW-1:0]     ja_q [JOIN_N];
  logic [AW-1:0]     jb_q [JOIN_N];
  logic [1:0]        j_idx_q, j_last_q;
  out_item_t         out_q;

  // Link tables
  logic [AW-1:0] next_mem [DEPTH];
  logic [AW-1:0] prev_mem [DEPTH];
  logic [AW-1:0] next_rd_q, prev_rd_q;
  logic          rd_en;
  logic [AW-1:0] rd_a;
  logic          next_we, prev_we;
  logic [AW-1:0] next_wa, next_wd, prev_wa, prev_wd;

  // Item numbers at table width
  logic [CW-1:0] x_c, y_c, len_c, n_c;
  logic [AW-1:0] x_a, y_a;

  assign x_c = CW'(item_q.item_x);
  assign y_c = CW'(item_q.item_y);
  assign x_a = x_c[AW-1:0];
  assign y_a = y_c[AW-1:0];

  // Clamp the configured length to the table size
  assign len_c = CW'(list_len_q);
  always_comb begin
    if (len_c == '0) n_c = CW'(1);
    else if (len_c > MAX_C) n_c = MAX_C;
    else n_c = len_c;
  end

  // Rearrange: pick effective ends and the joins to perform
  logic          is_swap, go_left, swp, skip_c;
  logic [AW-1:0] xe, ye, lx, rx, ly, ry;
  logic [AW-1:0] ja_c [JOIN_N];
  logic [AW-1:0] jb_c [JOIN_N];
  logic [1:0]    last_c;

  assign is_swap = (item_q.mode == MODE_SWAP);
  assign go_left = ((item_q.mode == MODE_LEFT) && !reversed_q) ||
                   ((item_q.mode == MODE_RIGHT) && reversed_q);
  assign swp     = is_swap && (ny_q == x_a);

  always_comb begin
    if (swp) begin
      xe = y_a;  ye = x_a;
      lx = py_q; rx = ny_q;
      ly = prev_rd_q; ry = next_rd_q;
    end else begin
      xe = x_a;  ye = y_a;
      lx = prev_rd_q; rx = next_rd_q;
      ly = py_q; ry = ny_q;
    end
  end

  always_comb begin
    if (is_swap) skip_c = 1'b0;
    else if (go_left) skip_c = (rx == ye);
    else skip_c = (ry == xe);
  end

  always_comb begin
    for (int j = 0; j < JOIN_N; j++) begin
      ja_c[j] = '0;
      jb_c[j] = '0;
    end
    last_c = 2'd2;
    if (!is_swap && go_left) begin
      ja_c[0] = lx; jb_c[0] = rx;
      ja_c[1] = ly; jb_c[1] = xe;
      ja_c[2] = xe; jb_c[2] = ye;
    end else if (!is_swap) begin
      ja_c[0] = lx; jb_c[0] = rx;
      ja_c[1] = xe; jb_c[1] = ry;
      ja_c[2] = ye; jb_c[2] = xe;
    end else if (rx == ye) begin
      ja_c[0] = lx; jb_c[0] = ye;
      ja_c[1] = ye; jb_c[1] = xe;
      ja_c[2] = xe; jb_c[2] = ry;
    end else begin
      ja_c[0] = lx; jb_c[0] = ye;
      ja_c[1] = ye; jb_c[1] = rx;
      ja_c[2] = ly; jb_c[2] = xe;
      ja_c[3] = xe; jb_c[3] = ry;
      last_c  = 2'd3;
    end
  end

  // Walk: follow the link for the current direction, saturate the sum
  logic [AW-1:0]    link;
  logic [SW-1:0]    sum_w;
  logic [SUM_W-1:0] sum_n;
  logic             walk_end;

  assign link     = reversed_q ? prev_rd_q : next_rd_q;
  assign sum_w    = SW'(sum_q) + SW'(link);
  assign sum_n    = (sum_w > SW'(SUM_MAX)) ? SUM_MAX : sum_w[SUM_W-1:0];
  assign walk_end = (cnt_q == active_q) || (link == '0) || (link > MAX_A);

  // Table port selection
  always_comb begin
    rd_en   = cmd_i.rd_y | cmd_i.rd_x | cmd_i.walk_rd;
    rd_a    = cmd_i.rd_y ? y_a : (cmd_i.rd_x ? x_a : pos_q);
    next_we = 1'b0;
    prev_we = 1'b0;
    next_wa = cnt_q;
    next_wd = (cnt_q == active_q) ? '0 : AW'(cnt_q + 1'b1);
    prev_wa = cnt_q;
    prev_wd = AW'(cnt_q - 1'b1);
    if (cmd_i.init_step) begin
      next_we = 1'b1;
      prev_we = 1'b1;
    end else if (cmd_i.init_head) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      next_wa = '0;
      next_wd = AW'(1);
      prev_wa = '0;
      prev_wd = active_q;
    end else if (cmd_i.join_step) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      next_wa = ja_q[j_idx_q];
      next_wd = jb_q[j_idx_q];
      prev_wa = jb_q[j_idx_q];
      prev_wd = ja_q[j_idx_q];
    end
  end

  // Link table memories with registered reads
  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (rd_en) next_rd_q <= next_mem[rd_a];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (rd_en) prev_rd_q <= prev_mem[rd_a];
  end

  // Configuration and list control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len_q <= LIST_LEN_RST;
      active_q   <= '0;
      reversed_q <= 1'b0;
    end else begin
      if (cfg_we_i) list_len_q <= cfg_wdata_i;
      if (cmd_i.init_start) begin
        active_q   <= n_c[AW-1:0];
        reversed_q <= 1'b0;
      end else if (cmd_i.flip_rev) begin
        reversed_q <= ~reversed_q;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q   <= in_data_i;
      sum_q    <= '0;
      status_q <= ST_DONE;
    end
    if (cmd_i.set_bad) status_q <= ST_BAD;
    if (cmd_i.init_start) cnt_q <= AW'(1);
    if (cmd_i.init_step) cnt_q <= AW'(cnt_q + 1'b1);
    if (cmd_i.rd_x) begin
      py_q <= prev_rd_q;
      ny_q <= next_rd_q;
    end
    if (cmd_i.calc) begin
      if (skip_c) status_q <= ST_SKIP;
      for (int j = 0; j < JOIN_N; j++) begin
        ja_q[j] <= ja_c[j];
        jb_q[j] <= jb_c[j];
      end
      j_idx_q  <= '0;
      j_last_q <= last_c;
    end
    if (cmd_i.join_step) j_idx_q <= j_idx_q + 1'b1;
    if (cmd_i.walk_start) begin
      cnt_q <= '0;
      pos_q <= '0;
    end
    if (cmd_i.walk_acc && !walk_end) begin
      if (!cnt_q[0]) sum_q <= sum_n;
      cnt_q <= AW'(cnt_q + 1'b1);
      pos_q <= link;
    end
    if (cmd_i.out_load) begin
      out_q.odd_sum <= sum_q;
      out_q.status  <= status_q;
    end
  end

  // Status back to the controller
  assign stat_o.mode      = item_q.mode;
  assign stat_o.bad       = (x_c == y_c) || (x_c == '0) || (y_c == '0) ||
                            (x_c > CW'(active_q)) || (y_c > CW'(active_q));
  assign stat_o.skip      = skip_c;
  assign stat_o.init_last = (cnt_q == active_q);
  assign stat_o.join_last = (j_idx_q == j_last_q);
  assign stat_o.walk_end  = walk_end;

  assign out_data_o = out_q;

endmodule

// ===== hw/rtl/indexed_linked_list_engine_unit.sv =====
// Indexed linked list engine: ordered item list in next/prev link tables.
// Reverse flips the list direction; invalid moves go straight to the result. Other moves
// and swaps read two links, then make one join write per cycle unless the move is skipped;
// init writes one link pair per item, then the head links; odd sum reads and adds per item.
// The next transfer is taken back in IDLE, once the result has gone to the output register.
// Reset clears control state and sets list_length to 1024; link tables hold garbage until init.
module indexed_linked_list_engine_unit import ille_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ITEM_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  ille_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Tables and arithmetic
  ille_dpath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule
